// ===== rtl/earf_pkg.sv =====
// package: shared constants, types and hash helpers for the receive address filter
`timescale 1ns / 1ps
package earf_pkg;

	localparam int MAC_W      = 48;
	localparam int CFG_W      = 64;
	localparam int FILTER_W   = 64;
	localparam int HASH_W     = 6;
	localparam int HASH_SHIFT = 26;
	localparam int CRC_W      = 32;
	localparam int GROUP_BIT  = 40;
	localparam int CFG_IDX_W  = 2;
	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STATION_MAC    = 2'd0,
		CFG_LOGICAL_FILTER = 2'd1,
		CFG_PROMISCUOUS    = 2'd2,
		CFG_LOOPBACK_MODE  = 2'd3
	} cfg_idx_t;

	// filter outcome codes
	typedef enum logic [2:0] {
		VERDICT_ACCEPT     = 3'd0,
		VERDICT_HASH_MISS  = 3'd1,
		VERDICT_UCAST_MISS = 3'd2,
		VERDICT_SELF_LOOP  = 3'd3,
		VERDICT_OWN_BCAST  = 3'd4
	} verdict_t;

	// configuration registers as one group
	typedef struct packed {
		logic [MAC_W-1:0]    station_mac;
		logic [FILTER_W-1:0] logical_filter;
		logic                promiscuous;
		logic                loopback_mode;
	} cfg_t;

	typedef logic [HASH_W-1:0][MAC_W-1:0] hash_mask_t;

	// bit-serial crc over the six address bytes, wire order, lsb first;
	// evaluated only at elaboration to derive the parity masks
	function automatic logic [HASH_W-1:0] crc_hash_model(input logic [MAC_W-1:0] mac);
		logic [CRC_W-1:0] crc;
		logic             fb;
		crc = '1;
		for (int i = 0; i < MAC_W / 8; i++) begin
			for (int b = 0; b < 8; b++) begin
				fb  = crc[0] ^ mac[MAC_W - 8 - 8 * i + b];
				crc = {1'b0, crc[CRC_W-1:1]} ^ (fb ? CRC_POLY : '0);
			end
		end
		return crc[HASH_SHIFT +: HASH_W];
	endfunction

	// the crc is affine in the address: one parity mask per hash bit
	function automatic hash_mask_t build_hash_masks();
		hash_mask_t             m;
		logic [HASH_W-1:0]      base;
		logic [HASH_W-1:0]      col;
		m    = '0;
		base = crc_hash_model('0);
		for (int j = 0; j < MAC_W; j++) begin
			col = crc_hash_model(MAC_W'(1) << j) ^ base;
			for (int k = 0; k < HASH_W; k++) begin
				m[k][j] = col[k];
			end
		end
		return m;
	endfunction

	localparam hash_mask_t        HASH_MASK = build_hash_masks();
	localparam logic [HASH_W-1:0] HASH_BASE = crc_hash_model('0);

endpackage

// ===== rtl/earf_if.sv =====
// interfaces: frame header request channel and filter result channel
`timescale 1ns / 1ps

interface earf_req_if import earf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [MAC_W-1:0] dest_mac;
	logic [MAC_W-1:0] src_mac;

	modport source (output valid, output dest_mac, output src_mac, input ready);
	modport sink   (input valid, input dest_mac, input src_mac, output ready);
endinterface

interface earf_res_if import earf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              accept;
	logic [2:0]        verdict;
	logic [HASH_W-1:0] hash_index;

	modport source (output valid, output accept, output verdict, output hash_index,
		input ready);
	modport sink   (input valid, input accept, input verdict, input hash_index,
		output ready);
endinterface

// ===== rtl/earf_cfg_regs.sv =====
// configuration register file written through the plain write port
`timescale 1ns / 1ps
module earf_cfg_regs import earf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// register writes, extra data bits dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_STATION_MAC:    cfg_q.station_mac    <= cfg_wdata[MAC_W-1:0];
				CFG_LOGICAL_FILTER: cfg_q.logical_filter <= cfg_wdata[FILTER_W-1:0];
				CFG_PROMISCUOUS:    cfg_q.promiscuous    <= cfg_wdata[0];
				CFG_LOOPBACK_MODE:  cfg_q.loopback_mode  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/earf_hash.sv =====
// multicast hash: top bits of the crc of the destination as parity trees
`timescale 1ns / 1ps
module earf_hash import earf_pkg::*; (
	input  logic [MAC_W-1:0]  dest_mac,
	output logic [HASH_W-1:0] hash_index
);

	// each hash bit is the parity of a fixed subset of address bits, xored with a constant
	always_comb begin
		for (int k = 0; k < HASH_W; k++) begin
			hash_index[k] = (^(dest_mac & HASH_MASK[k])) ^ HASH_BASE[k];
		end
	end

endmodule

// ===== rtl/earf_decide.sv =====
// address tests and verdict selection for one frame header
`timescale 1ns / 1ps
module earf_decide import earf_pkg::*; (
	input  cfg_t              cfg,
	input  logic [MAC_W-1:0]  dest_mac,
	input  logic [MAC_W-1:0]  src_mac,
	input  logic [HASH_W-1:0] hash_index,
	output verdict_t          verdict
);

	logic is_group;
	logic is_bcast;
	logic dst_is_me;
	logic src_is_me;
	logic hash_hit;

	assign is_group  = dest_mac[GROUP_BIT];
	assign is_bcast  = &dest_mac;
	assign dst_is_me = dest_mac == cfg.station_mac;
	assign src_is_me = src_mac == cfg.station_mac;
	assign hash_hit  = cfg.logical_filter[hash_index];

	// outside loopback mode: address test, then self loop, then own broadcast
	always_comb begin
		verdict = VERDICT_ACCEPT;
		if (!cfg.loopback_mode) begin
			if (!cfg.promiscuous && !is_bcast) begin
				if (is_group) begin
					if (!hash_hit) begin
						verdict = VERDICT_HASH_MISS;
					end
				end else if (!dst_is_me) begin
					verdict = VERDICT_UCAST_MISS;
				end
			end
			if (verdict == VERDICT_ACCEPT && dst_is_me && src_is_me) begin
				verdict = VERDICT_SELF_LOOP;
			end
			if (verdict == VERDICT_ACCEPT && is_bcast && src_is_me) begin
				verdict = VERDICT_OWN_BCAST;
			end
		end
	end

endmodule

// ===== rtl/ethernet_rx_address_filter_unit.sv =====
// top level: receive address filter with input register and result register
`timescale 1ns / 1ps
// Receive address filter. Each request transaction carries a frame's destination
// and source address; each one yields exactly one result transaction with the
// accept flag, a verdict code and the multicast hash of the destination. The
// block takes one request per clock while the result side keeps up; each request
// is held in the input register, then goes through the hash parity trees and the
// address compares into the result register. A stalled result side holds the
// result register; ready on the request side drops only once the input register
// is full as well. Configuration is written through cfg_we/cfg_index/cfg_wdata
// and must only change while no transaction is in flight.
module ethernet_rx_address_filter_unit import earf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	earf_req_if.sink             req,
	earf_res_if.source           res
);

	cfg_t              cfg;
	logic              valid_s1;
	logic [MAC_W-1:0]  dest_mac_s1;
	logic [MAC_W-1:0]  src_mac_s1;
	logic [HASH_W-1:0] hash_s1;
	verdict_t          verdict_s1;
	logic              valid_s2;
	logic              accept_s2;
	verdict_t          verdict_s2;
	logic [HASH_W-1:0] hash_s2;
	logic              adv_s2;

	earf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// pipeline flow control
	assign adv_s2    = !valid_s2 || res.ready;
	assign req.ready = !valid_s1 || adv_s2;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			dest_mac_s1 <= req.dest_mac;
			src_mac_s1  <= req.src_mac;
		end
	end

	earf_hash u_hash (
		.dest_mac   (dest_mac_s1),
		.hash_index (hash_s1)
	);

	earf_decide u_decide (
		.cfg        (cfg),
		.dest_mac   (dest_mac_s1),
		.src_mac    (src_mac_s1),
		.hash_index (hash_s1),
		.verdict    (verdict_s1)
	);

	// result register
	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			accept_s2  <= verdict_s1 == VERDICT_ACCEPT;
			verdict_s2 <= verdict_s1;
			hash_s2    <= hash_s1;
		end
	end

	assign res.valid      = valid_s2;
	assign res.accept     = accept_s2;
	assign res.verdict    = 3'(verdict_s2);
	assign res.hash_index = hash_s2;

	// accept flag agrees with the verdict code
	a_accept_matches_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (accept_s2 == (verdict_s2 == VERDICT_ACCEPT)))
		else $error("accept flag disagrees with verdict");

	// loopback mode never drops a frame
	a_loopback_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && cfg.loopback_mode) |-> accept_s2)
		else $error("frame dropped in loopback mode");

	// request side only stalls when both stages are full and the result side is not ready
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && valid_s2 && !res.ready))
		else $error("request stalled with room in the pipeline");

	// a held result keeps its hash
	a_hash_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res.ready) |=> (valid_s2 && $stable(hash_s2)))
		else $error("stalled result changed");

endmodule

// ===== verif/tb_ethernet_rx_address_filter_unit.sv =====
// testbench: directed and randomized check of the receive address filter against an in-bench predictor
`timescale 1ns / 1ps

module tb_ethernet_rx_address_filter_unit;
	import earf_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int DRAIN_CYCLES  = 4;
	localparam int RANDOM_ITEMS  = 1400;
	localparam int QUIET_ITEMS   = 200;
	localparam int REPORT_LIMIT  = 10;

	// predicted filter decisions and their comparison with the block
	class filter_scoreboard;
		typedef struct {
			logic [MAC_W-1:0]  dest_mac;
			logic [MAC_W-1:0]  src_mac;
			logic              accept;
			verdict_t          verdict;
			logic [HASH_W-1:0] hash_index;
		} decision_t;

		logic [MAC_W-1:0]    station_mac;
		logic [FILTER_W-1:0] hash_filter;
		logic                promisc;
		logic                loopback;
		decision_t           pending_decisions[$];
		int                  failures;

		function new();
			station_mac = '0;
			hash_filter = '0;
			promisc     = 1'b0;
			loopback    = 1'b0;
			failures    = 0;
		endfunction

		// reflected crc-32, all ones preset, no final inversion, wire order lsb first
		static function logic [HASH_W-1:0] crc_hash(input logic [MAC_W-1:0] mac);
			logic [31:0] crc;
			logic [7:0]  octet;
			logic        fb;
			crc = 32'hFFFF_FFFF;
			for (int i = 0; i < MAC_W / 8; i++) begin
				octet = mac[MAC_W - 1 - 8 * i -: 8];
				for (int b = 0; b < 8; b++) begin
					fb  = crc[0] ^ octet[b];
					crc = crc >> 1;
					if (fb) crc = crc ^ 32'hEDB8_8320;
				end
			end
			return crc[31 -: HASH_W];
		endfunction

		function void set_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
			case (idx)
				CFG_STATION_MAC:    station_mac = value[MAC_W-1:0];
				CFG_LOGICAL_FILTER: hash_filter = value[FILTER_W-1:0];
				CFG_PROMISCUOUS:    promisc     = value[0];
				CFG_LOOPBACK_MODE:  loopback    = value[0];
				default: ;
			endcase
		endfunction

		function void flag(input string msg);
			failures++;
			if (failures <= REPORT_LIMIT) $display("%t: %s", $realtime, msg);
		endfunction

		function int pending();
			return pending_decisions.size();
		endfunction

		// accepted request transaction: work out the decision
		function void note_frame(input logic [MAC_W-1:0] dst, input logic [MAC_W-1:0] src);
			decision_t d;
			logic      bcast;
			d.dest_mac   = dst;
			d.src_mac    = src;
			d.hash_index = crc_hash(dst);
			d.verdict    = VERDICT_ACCEPT;
			bcast        = (dst == '1);
			if (!loopback) begin
				// address test, skipped for broadcast and in promiscuous mode
				if (!promisc && !bcast) begin
					if (dst[GROUP_BIT]) begin
						if (!hash_filter[d.hash_index]) d.verdict = VERDICT_HASH_MISS;
					end else if (dst != station_mac) begin
						d.verdict = VERDICT_UCAST_MISS;
					end
				end
				if (d.verdict == VERDICT_ACCEPT && dst == station_mac && src == station_mac)
					d.verdict = VERDICT_SELF_LOOP;
				if (d.verdict == VERDICT_ACCEPT && bcast && src == station_mac)
					d.verdict = VERDICT_OWN_BCAST;
			end
			d.accept = (d.verdict == VERDICT_ACCEPT);
			pending_decisions.push_back(d);
		endfunction

		// accepted result transaction: compare with the oldest decision
		function void check_result(input logic acc, input logic [2:0] vd,
			input logic [HASH_W-1:0] hash);
			decision_t d;
			if (pending_decisions.size() == 0) begin
				flag($sformatf("unexpected result accept %b verdict %0d hash %0d",
					acc, vd, hash));
				return;
			end
			d = pending_decisions.pop_front();
			if (acc !== d.accept || vd !== d.verdict || hash !== d.hash_index)
				flag($sformatf({"mismatch dest %h src %h: expected accept %b verdict %0d ",
					"hash %0d, got accept %b verdict %0d hash %0d"}, d.dest_mac, d.src_mac,
					d.accept, d.verdict, d.hash_index, acc, vd, hash));
		endfunction

		function void close();
			if (pending_decisions.size() != 0)
				flag($sformatf("%0d results never arrived", pending_decisions.size()));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	cfg_idx_t             cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	bit                   idle_on;
	int                   idle_cycles;
	logic [MAC_W-1:0]     group_pool [4];
	filter_scoreboard     sb = new();

	earf_req_if req ();
	earf_res_if res ();

	ethernet_rx_address_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.res       (res)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// transaction monitors and watchdog
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) sb.note_frame(req.dest_mac, req.src_mac);
		if (arst_n && res.valid && res.ready)
			sb.check_result(res.accept, res.verdict, res.hash_index);
		if (!arst_n || (req.valid && req.ready) || (res.valid && res.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL ethernet_rx_address_filter_unit");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side backpressure in random bursts while idling is on
	initial begin
		int n;
		res.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 4) == 0) begin
				res.ready <= 1'b0;
				n = $urandom_range(1, 17);
			end else begin
				res.ready <= 1'b1;
				n = $urandom_range(1, 6);
			end
			repeat (n) @(posedge clk);
		end
	end

	function automatic logic [MAC_W-1:0] random_mac();
		return {16'($urandom()), $urandom()};
	endfunction

	function automatic logic [MAC_W-1:0] random_group_mac();
		logic [MAC_W-1:0] m;
		m            = random_mac();
		m[GROUP_BIT] = 1'b1;
		return m;
	endfunction

	function automatic logic [MAC_W-1:0] random_unicast_mac();
		logic [MAC_W-1:0] m;
		m            = random_mac();
		m[GROUP_BIT] = 1'b0;
		return m;
	endfunction

	// one request transaction, with an optional gap ahead of it
	task automatic send_frame(input logic [MAC_W-1:0] dst, input logic [MAC_W-1:0] src);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		req.valid    <= 1'b1;
		req.dest_mac <= dst;
		req.src_mac  <= src;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// stop sending and wait until every result is back
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all four registers, junk in the bits above the station address and flag widths
	task automatic apply_config(input logic [MAC_W-1:0] st, input logic [FILTER_W-1:0] filt,
		input logic pr, input logic lb);
		cfg_idx_t         order [4];
		logic [CFG_W-1:0] words [4];
		order    = '{CFG_STATION_MAC, CFG_LOGICAL_FILTER, CFG_PROMISCUOUS, CFG_LOOPBACK_MODE};
		words[0] = {16'($urandom()), st};
		words[1] = filt;
		words[2] = {$urandom(), 31'($urandom()), pr};
		words[3] = {$urandom(), 31'($urandom()), lb};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= order[i];
			cfg_wdata <= words[i];
			@(posedge clk);
			sb.set_reg(order[i], words[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// directed frames covering every verdict and the corner cases
	task automatic directed_frames();
		logic [MAC_W-1:0] st;
		logic [MAC_W-1:0] st_grp;
		logic [MAC_W-1:0] m_hit;
		logic [MAC_W-1:0] m_miss;
		logic [FILTER_W-1:0] filt;
		st     = random_unicast_mac();
		st_grp = random_group_mac();
		m_hit  = random_group_mac();
		m_miss = random_group_mac();
		while (filter_scoreboard::crc_hash(m_miss) == filter_scoreboard::crc_hash(m_hit))
			m_miss = random_group_mac();

		// registers still at reset values
		send_frame('0, '0);
		send_frame('0, '1);
		send_frame('1, '0);
		send_frame(m_hit, random_mac());
		send_frame(random_unicast_mac() | 48'h1, random_mac());
		drain();

		// unicast station, single hash bit
		filt = '0;
		filt[filter_scoreboard::crc_hash(m_hit)] = 1'b1;
		apply_config(st, filt, 1'b0, 1'b0);
		send_frame(st, random_mac());
		send_frame(st, st);
		send_frame(m_hit, random_mac());
		send_frame(m_miss, random_mac());
		send_frame('1, st);
		send_frame('1, random_mac());
		send_frame(st ^ 48'h1, random_mac());
		send_frame(48'hFE_FF_FF_FF_FF_FF, '1);
		drain();

		// promiscuous with a group station address
		apply_config(st_grp, '1, 1'b1, 1'b0);
		send_frame(st_grp, st_grp);
		send_frame('1, st_grp);
		send_frame(random_unicast_mac(), random_mac());
		send_frame('0, '0);
		drain();

		// group station address whose hash bit is clear
		apply_config(st_grp, '0, 1'b0, 1'b0);
		send_frame(st_grp, st_grp);
		drain();

		// station equal to broadcast
		apply_config('1, '0, 1'b0, 1'b0);
		send_frame('1, '1);
		send_frame('1, '0);
		drain();

		// loopback bypasses every test
		apply_config(st, '0, 1'b0, 1'b1);
		send_frame(st, st);
		send_frame('1, st);
		send_frame(m_miss, random_mac());
		send_frame(random_unicast_mac(), random_mac());
		drain();
	endtask

	// one random register setting followed by a run of frames
	task automatic random_phase(input int count);
		logic [MAC_W-1:0]    st;
		logic [FILTER_W-1:0] filt;
		logic [MAC_W-1:0]    dst;
		logic [MAC_W-1:0]    src;
		int                  pick;
		foreach (group_pool[k]) group_pool[k] = random_group_mac();
		case ($urandom_range(0, 5))
			0: st = '0;
			1: st = '1;
			2: st = group_pool[0];
			default: st = random_unicast_mac();
		endcase
		case ($urandom_range(0, 4))
			0: filt = '0;
			1: filt = '1;
			2: filt = {$urandom(), $urandom()};
			default: begin
				filt = '0;
				foreach (group_pool[k])
					if ($urandom_range(0, 3) != 0)
						filt[filter_scoreboard::crc_hash(group_pool[k])] = 1'b1;
			end
		endcase
		apply_config(st, filt, $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0);

		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 20)      dst = st;
			else if (pick < 35) dst = '1;
			else if (pick < 60) dst = group_pool[$urandom_range(0, 3)];
			else if (pick < 75) dst = random_group_mac();
			else if (pick < 85) dst = random_unicast_mac();
			else if (pick < 92) dst = st ^ (48'h1 << $urandom_range(0, MAC_W - 1));
			else                dst = random_mac();
			pick = $urandom_range(0, 99);
			if (pick < 40)      src = st;
			else if (pick < 50) src = '1;
			else                src = random_mac();
			send_frame(dst, src);
		end
		drain();
	endtask

	// main sequence
	initial begin
		int sent;
		int n;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= CFG_STATION_MAC;
		cfg_wdata    <= '0;
		req.valid    <= 1'b0;
		req.dest_mac <= '0;
		req.src_mac  <= '0;
		idle_on      = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_frames();

		// random settings, idling switched on and off per phase
		sent = 0;
		while (sent < RANDOM_ITEMS - QUIET_ITEMS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			n       = $urandom_range(30, 150);
			random_phase(n);
			sent += n;
		end
		// closing stretch at full rate
		idle_on = 1'b0;
		random_phase(QUIET_ITEMS);

		sb.close();
		if (sb.failures == 0) begin
			$display("PASS ethernet_rx_address_filter_unit");
		end else begin
			$display("FAIL ethernet_rx_address_filter_unit");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/earf_pkg.sv
rtl/earf_if.sv
rtl/earf_cfg_regs.sv
rtl/earf_hash.sv
rtl/earf_decide.sv
rtl/ethernet_rx_address_filter_unit.sv
verif/tb_ethernet_rx_address_filter_unit.sv
